### src/assert_macros.svh
// Assertion helpers included by the deadzone core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/gasd_pkg.sv
package gasd_pkg;

    // Event kinds
    localparam logic [1:0] KIND_BUTTON = 2'd0;
    localparam logic [1:0] KIND_AXIS   = 2'd1;
    localparam logic [1:0] KIND_OTHER  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Button numbers of the analog triggers
    localparam logic [7:0] CTRL_L2 = 8'h06;
    localparam logic [7:0] CTRL_R2 = 8'h07;

    // Axis numbers (low three bits of the control number)
    localparam logic [2:0] AXIS_LX    = 3'd0;
    localparam logic [2:0] AXIS_LY    = 3'd1;
    localparam logic [2:0] AXIS_L2    = 3'd2;
    localparam logic [2:0] AXIS_RX    = 3'd3;
    localparam logic [2:0] AXIS_RY    = 3'd4;
    localparam logic [2:0] AXIS_R2    = 3'd5;
    localparam logic [2:0] AXIS_HAT_X = 3'd6;
    localparam logic [2:0] AXIS_HAT_Y = 3'd7;

    // Coordinate pairs
    localparam logic [1:0] PAIR_LEFT  = 2'd0;
    localparam logic [1:0] PAIR_RIGHT = 2'd1;
    localparam logic [1:0] PAIR_TRIG  = 2'd2;
    localparam logic [1:0] PAIR_HAT   = 2'd3;

    localparam int unsigned NUM_PAIRS = 4;

    localparam logic [14:0]        DEADZONE_RESET = 15'd5000;
    localparam logic signed [15:0] COORD_MAX      = 16'sd32767;
    localparam logic signed [15:0] COORD_MIN      = -16'sd32767;
    localparam logic signed [15:0] COORD_LOWEST   = -16'sd32768;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         control_num;
        logic signed [15:0] event_value;
    } req_t;

    typedef struct packed {
        logic [1:0]         pair_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } rsp_t;

    // Map an axis number to the pair it belongs to
    function automatic logic [1:0] axis_to_pair(input logic [2:0] axis);
        logic [1:0] pair;
        unique case (axis)
            AXIS_LX, AXIS_LY:       pair = PAIR_LEFT;
            AXIS_RX, AXIS_RY:       pair = PAIR_RIGHT;
            AXIS_L2, AXIS_R2:       pair = PAIR_TRIG;
            AXIS_HAT_X, AXIS_HAT_Y: pair = PAIR_HAT;
            default:                pair = PAIR_LEFT;
        endcase
        return pair;
    endfunction

    // Magnitude of a coordinate that never holds the lowest code
    function automatic logic [14:0] coord_mag(input logic signed [15:0] c);
        logic signed [15:0] m;
        m = c[15] ? -c : c;
        return m[14:0];
    endfunction

endpackage

### src/gamepad_axis_square_deadzone_core.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------
// request  | req_valid / req_stall | req : event kind, control number, value
// response | rsp_valid / rsp_stall | rsp : pair index, x, y
// config   | cfg_wr_en             | cfg_wr_data : deadzone half side
//
// One event per cycle unless rsp_stall holds a full response: an event waits
// in the input register until it fires, and the pair update and response
// load happen then; rsp_valid is set only by axis events past the deadzone.
// rsp_stall backs up into req_stall only when both registers are full.
// rst_n (async, active low) clears all pairs and sets the deadzone to 5000.
`include "assert_macros.svh"

module gamepad_axis_square_deadzone_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  gasd_pkg::req_t      req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output gasd_pkg::rsp_t      rsp,
    input  logic                cfg_wr_en,
    input  logic [14:0]         cfg_wr_data
);

    logic                 s1_valid_reg, s1_valid_next;
    gasd_pkg::req_t       s1_reg;
    logic                 rsp_valid_reg, rsp_valid_next;
    gasd_pkg::rsp_t       rsp_reg;
    logic [14:0]          dz_reg;
    logic signed [15:0]   pair_x_reg [gasd_pkg::NUM_PAIRS];
    logic signed [15:0]   pair_y_reg [gasd_pkg::NUM_PAIRS];
    logic signed [15:0]   pair_x_next [gasd_pkg::NUM_PAIRS];
    logic signed [15:0]   pair_y_next [gasd_pkg::NUM_PAIRS];

    logic                 out_free;
    logic                 fire;
    logic                 accept;
    logic                 axis_ok;
    logic                 release_evt;
    logic                 in_dz;
    logic                 emit;
    logic                 val_lowest;
    logic signed [15:0]   val_direct;
    logic signed [15:0]   val_neg;
    logic [1:0]           pair;
    logic signed [15:0]   new_x;
    logic signed [15:0]   new_y;
    logic [14:0]          mag_x;
    logic [14:0]          mag_y;
    logic [14:0]          mag_big;

    // Handshake: process the held event when the response slot is free
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign fire      = s1_valid_reg && out_free;
    assign req_stall = s1_valid_reg && !out_free;
    assign accept    = req_valid && !req_stall;

    // Saturate the value, direct and negated
    assign val_lowest = (s1_reg.event_value == gasd_pkg::COORD_LOWEST);
    assign val_direct = val_lowest ? gasd_pkg::COORD_MIN : s1_reg.event_value;
    assign val_neg    = val_lowest ? gasd_pkg::COORD_MAX : -s1_reg.event_value;

    assign axis_ok = (s1_reg.req_type == gasd_pkg::KIND_AXIS)
                  && (s1_reg.control_num[7:3] == 5'd0);
    assign release_evt = (s1_reg.req_type == gasd_pkg::KIND_BUTTON)
                      && (s1_reg.event_value == 16'sd0);
    assign pair = gasd_pkg::axis_to_pair(s1_reg.control_num[2:0]);

    // Build the updated pair
    always_comb
    begin
        new_x = pair_x_reg[pair];
        new_y = pair_y_reg[pair];
        case (s1_reg.control_num[2:0]) inside
            gasd_pkg::AXIS_LX, gasd_pkg::AXIS_RX, gasd_pkg::AXIS_HAT_X:
                new_x = val_direct;
            gasd_pkg::AXIS_L2:
                new_x = val_neg;
            default:
                new_y = val_neg;
        endcase
    end

    // Square deadzone test on the larger magnitude; triggers are exempt
    assign mag_x   = gasd_pkg::coord_mag(new_x);
    assign mag_y   = gasd_pkg::coord_mag(new_y);
    assign mag_big = (mag_x > mag_y) ? mag_x : mag_y;
    assign in_dz   = (pair != gasd_pkg::PAIR_TRIG) && (mag_big < dz_reg);
    assign emit    = fire && axis_ok && !in_dz;

    // Next pair state: axis update or trigger release
    always_comb
    begin
        for (int i = 0; i < gasd_pkg::NUM_PAIRS; i++)
        begin
            pair_x_next[i] = pair_x_reg[i];
            pair_y_next[i] = pair_y_reg[i];
        end
        if (fire && axis_ok)
        begin
            pair_x_next[pair] = in_dz ? 16'sd0 : new_x;
            pair_y_next[pair] = in_dz ? 16'sd0 : new_y;
        end
        else if (fire && release_evt)
        begin
            if (s1_reg.control_num == gasd_pkg::CTRL_L2)
                pair_x_next[gasd_pkg::PAIR_TRIG] = 16'sd0;
            if (s1_reg.control_num == gasd_pkg::CTRL_R2)
                pair_y_next[gasd_pkg::PAIR_TRIG] = 16'sd0;
        end
    end

    // Next valid flags
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;

        rsp_valid_next = rsp_valid_reg;
        if (emit)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    // Control state, pairs and deadzone
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            dz_reg        <= gasd_pkg::DEADZONE_RESET;
            for (int i = 0; i < gasd_pkg::NUM_PAIRS; i++)
            begin
                pair_x_reg[i] <= 16'sd0;
                pair_y_reg[i] <= 16'sd0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
                dz_reg <= cfg_wr_data;
            for (int i = 0; i < gasd_pkg::NUM_PAIRS; i++)
            begin
                pair_x_reg[i] <= pair_x_next[i];
                pair_y_reg[i] <= pair_y_next[i];
            end
        end
    end

    // Payload registers: capture on transfer, load response on emit
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= req;
        if (emit)
        begin
            rsp_reg.pair_index <= pair;
            rsp_reg.pos_x      <= new_x;
            rsp_reg.pos_y      <= new_y;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Backpressure reaches the request side only with an event held
    `ASSERT_ALWAYS(a_stall_needs_held, req_stall |-> s1_valid_reg,
        "req_stall without held event")

    // A reported stick pair is never inside a nonzero deadzone at the origin
    `ASSERT_CLK(a_no_zero_stick,
        (rsp_valid && rsp.pair_index != gasd_pkg::PAIR_TRIG && dz_reg != 15'd0)
            |-> (rsp.pos_x != 16'sd0 || rsp.pos_y != 16'sd0),
        "stick pair reported at origin")

    // Reported coordinates never reach the lowest code
    `ASSERT_CLK(a_coord_range,
        rsp_valid |-> (rsp.pos_x != gasd_pkg::COORD_LOWEST
                       && rsp.pos_y != gasd_pkg::COORD_LOWEST),
        "coordinate out of range")

endmodule
